// ===== hw/rtl/rskp_pkg.sv =====
// shared types, constants and helpers for the robust scalar kalman position filter
package rskp_pkg;

    localparam int POS_FRAC_BITS_DEF = 4;
    localparam int DIV_W    = 65;   // dividend / quotient width of the shared divider
    localparam int DVS_W    = 35;   // divisor width
    localparam int MA_W     = 34;
    localparam int MB_W     = 17;
    localparam int PROD_W   = MA_W + MB_W;
    localparam int CNT_W    = 7;

    localparam logic [11:0] SCREEN_WIDTH_RST  = 12'd1920;
    localparam logic [11:0] SCREEN_HEIGHT_RST = 12'd1080;
    localparam logic [9:0]  BORDER_MARGIN_RST = 10'd100;
    localparam logic [15:0] CLIP_RST          = 16'd77;
    localparam logic [15:0] Q_CENTER_RST      = 16'd50;
    localparam logic [15:0] R_CENTER_RST      = 16'd10;
    localparam logic [15:0] Q_BORDER_RST      = 16'd50;
    localparam logic [15:0] R_BORDER_RST      = 16'd10;
    localparam logic [31:0] VAR_RST           = 32'h000A_0000;

    // register indexes
    localparam logic [2:0] REG_SCREEN_WIDTH  = 3'd0;
    localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd1;
    localparam logic [2:0] REG_BORDER_MARGIN = 3'd2;
    localparam logic [2:0] REG_CLIP          = 3'd3;
    localparam logic [2:0] REG_Q_CENTER      = 3'd4;
    localparam logic [2:0] REG_R_CENTER      = 3'd5;
    localparam logic [2:0] REG_Q_BORDER      = 3'd6;
    localparam logic [2:0] REG_R_BORDER      = 3'd7;

    typedef logic [2:0] mul_op_t;
    localparam mul_op_t MUL_NONE  = 3'd0;
    localparam mul_op_t MUL_RQ_AE = 3'd1;
    localparam mul_op_t MUL_B_SQ  = 3'd2;
    localparam mul_op_t MUL_NUM   = 3'd3;
    localparam mul_op_t MUL_VP_R  = 3'd4;

    typedef struct packed {
        logic    load;
        logic    prep1;
        logic    prep2;
        logic    prep3;
        logic    sqrt_step;
        mul_op_t mul_op;
        logic    lhs_cap;
        logic    clip_cap;
        logic    div_load_pos;
        logic    div_load_var;
        logic    div_step;
        logic    pos_upd;
        logic    var_upd;
        logic    out_load;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } sts_t;

    function automatic logic [15:0] center_of(input logic [11:0] size, input int frac);
        logic [20:0] c;
        c = ({9'b0, size} << frac) >> 1;
        return (c > 21'd32767) ? 16'd32767 : c[15:0];
    endfunction

endpackage

// ===== hw/rtl/rskp_ctrl.sv =====
// sequencer for one filter step: prep, square root, multiplies, two long divisions
module rskp_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  rskp_pkg::sts_t sts,
    output rskp_pkg::cmd_t cmd
);

    localparam logic [4:0] ST_IDLE    = 5'd0;
    localparam logic [4:0] ST_PREP1   = 5'd1;
    localparam logic [4:0] ST_PREP2   = 5'd2;
    localparam logic [4:0] ST_PREP3   = 5'd3;
    localparam logic [4:0] ST_SQRT    = 5'd4;
    localparam logic [4:0] ST_MUL_LHS = 5'd5;
    localparam logic [4:0] ST_MUL_RHS = 5'd6;
    localparam logic [4:0] ST_CLIP    = 5'd7;
    localparam logic [4:0] ST_MUL_NUM = 5'd8;
    localparam logic [4:0] ST_DIVP_LD = 5'd9;
    localparam logic [4:0] ST_DIVP    = 5'd10;
    localparam logic [4:0] ST_POS_UPD = 5'd11;
    localparam logic [4:0] ST_DIVV_LD = 5'd12;
    localparam logic [4:0] ST_DIVV    = 5'd13;
    localparam logic [4:0] ST_VAR_UPD = 5'd14;
    localparam logic [4:0] ST_FIN     = 5'd15;

    localparam logic [rskp_pkg::CNT_W-1:0] SQRT_LAST = rskp_pkg::CNT_W'(15);
    localparam logic [rskp_pkg::CNT_W-1:0] DIV_LAST  = rskp_pkg::CNT_W'(rskp_pkg::DIV_W - 1);

    logic [4:0]                 state_reg, state_next;
    logic [rskp_pkg::CNT_W-1:0] cnt_reg, cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.mul_op = rskp_pkg::MUL_NONE;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_PREP1;
                end
            end
            ST_PREP1: begin
                cmd.prep1  = 1'b1;
                state_next = ST_PREP2;
            end
            ST_PREP2: begin
                cmd.prep2  = 1'b1;
                state_next = ST_PREP3;
            end
            ST_PREP3: begin
                cmd.prep3  = 1'b1;
                cnt_next   = '0;
                state_next = ST_SQRT;
            end
            ST_SQRT: begin
                cmd.sqrt_step = 1'b1;
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg == SQRT_LAST) state_next = ST_MUL_LHS;
            end
            ST_MUL_LHS: begin
                cmd.mul_op = rskp_pkg::MUL_RQ_AE;
                state_next = ST_MUL_RHS;
            end
            ST_MUL_RHS: begin
                cmd.lhs_cap = 1'b1;
                cmd.mul_op  = rskp_pkg::MUL_B_SQ;
                state_next  = ST_CLIP;
            end
            ST_CLIP: begin
                cmd.clip_cap = 1'b1;
                state_next   = ST_MUL_NUM;
            end
            ST_MUL_NUM: begin
                cmd.mul_op = rskp_pkg::MUL_NUM;
                state_next = ST_DIVP_LD;
            end
            ST_DIVP_LD: begin
                cmd.div_load_pos = 1'b1;
                cnt_next         = '0;
                state_next       = ST_DIVP;
            end
            ST_DIVP: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST) state_next = ST_POS_UPD;
            end
            ST_POS_UPD: begin
                cmd.pos_upd = 1'b1;
                cmd.mul_op  = rskp_pkg::MUL_VP_R;
                state_next  = ST_DIVV_LD;
            end
            ST_DIVV_LD: begin
                cmd.div_load_var = 1'b1;
                cnt_next         = '0;
                state_next       = ST_DIVV;
            end
            ST_DIVV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST) state_next = ST_VAR_UPD;
            end
            ST_VAR_UPD: begin
                cmd.var_upd = 1'b1;
                state_next  = ST_FIN;
            end
            ST_FIN: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/rskp_dp.sv =====
// datapath: config and filter state, border select, square root, shared multiplier and divider
module rskp_dp #(
    parameter int POS_FRAC_BITS = rskp_pkg::POS_FRAC_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [2:0]          cfg_addr,
    input  logic [15:0]         cfg_wdata,
    input  logic                s_tuser,
    input  logic signed [15:0]  s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic                m_tuser,
    output logic signed [15:0]  m_tdata,
    input  rskp_pkg::cmd_t      cmd,
    output rskp_pkg::sts_t      sts
);

    localparam int DW    = rskp_pkg::DIV_W;
    localparam int VW    = rskp_pkg::DVS_W;
    localparam int PW    = rskp_pkg::PROD_W;
    localparam int AW    = rskp_pkg::MA_W;
    localparam int BW    = rskp_pkg::MB_W;
    localparam int BRD_W = 18 + POS_FRAC_BITS;
    localparam int CMP_W = PW + 1 + POS_FRAC_BITS;

    // configuration
    logic [11:0] width_reg, height_reg;
    logic [9:0]  margin_reg;
    logic [15:0] clip_reg_b, qc_reg, rc_reg, qb_reg, rb_reg;

    // per-axis filter state
    logic signed [15:0] est_st_reg [2];
    logic [31:0]        var_st_reg [2];

    // working registers
    logic               ax_reg;
    logic signed [15:0] s_reg;
    logic [15:0]        q_reg, r_reg;
    logic signed [15:0] est_reg;
    logic [31:0]        v_reg;
    logic [32:0]        vp_reg;
    logic [33:0]        sq_reg;
    logic               neg_reg;
    logic [16:0]        ae_reg;
    logic [31:0]        sx_reg;
    logic [17:0]        srem_reg;
    logic [15:0]        root_reg;
    logic [PW-1:0]      p_reg;
    logic [32:0]        lhs_reg;
    logic               clip_reg, zero_reg, sqz_reg;
    logic [DW-1:0]      dq_reg;
    logic [VW:0]        dr_reg;
    logic [VW-1:0]      dd_reg;
    logic signed [15:0] res_reg;
    logic               m_tvalid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= rskp_pkg::SCREEN_WIDTH_RST;
            height_reg <= rskp_pkg::SCREEN_HEIGHT_RST;
            margin_reg <= rskp_pkg::BORDER_MARGIN_RST;
            clip_reg_b <= rskp_pkg::CLIP_RST;
            qc_reg     <= rskp_pkg::Q_CENTER_RST;
            rc_reg     <= rskp_pkg::R_CENTER_RST;
            qb_reg     <= rskp_pkg::Q_BORDER_RST;
            rb_reg     <= rskp_pkg::R_BORDER_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                rskp_pkg::REG_SCREEN_WIDTH:  width_reg  <= cfg_wdata[11:0];
                rskp_pkg::REG_SCREEN_HEIGHT: height_reg <= cfg_wdata[11:0];
                rskp_pkg::REG_BORDER_MARGIN: margin_reg <= cfg_wdata[9:0];
                rskp_pkg::REG_CLIP:          clip_reg_b <= cfg_wdata;
                rskp_pkg::REG_Q_CENTER:      qc_reg     <= cfg_wdata;
                rskp_pkg::REG_R_CENTER:      rc_reg     <= cfg_wdata;
                rskp_pkg::REG_Q_BORDER:      qb_reg     <= cfg_wdata;
                rskp_pkg::REG_R_BORDER:      rb_reg     <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // border test
    logic [11:0]             size_sel;
    logic signed [BRD_W-1:0] lo_w, hi_w, s_w;
    logic                    interior;

    always_comb begin
        size_sel = ax_reg ? height_reg : width_reg;
        lo_w     = BRD_W'($signed({1'b0, margin_reg})) <<< POS_FRAC_BITS;
        hi_w     = (BRD_W'($signed({1'b0, size_sel})) - BRD_W'($signed({1'b0, margin_reg})))
                   <<< POS_FRAC_BITS;
        s_w      = BRD_W'(s_reg);
        interior = (s_w > lo_w) && (s_w < hi_w);
    end

    // innovation
    logic signed [16:0] e_w;
    assign e_w = 17'(s_reg) - 17'(est_reg);

    // square root digit step
    logic [19:0] rem2_w, trial_w;
    assign rem2_w  = {srem_reg, sx_reg[31:30]};
    assign trial_w = {2'b00, root_reg, 2'b01};

    // shared multiplier
    logic [AW-1:0] ma_w;
    logic [BW-1:0] mb_w;
    always_comb begin
        case (cmd.mul_op)
            rskp_pkg::MUL_RQ_AE: begin
                ma_w = AW'(root_reg);
                mb_w = ae_reg;
            end
            rskp_pkg::MUL_B_SQ: begin
                ma_w = sq_reg;
                mb_w = BW'(clip_reg_b);
            end
            rskp_pkg::MUL_NUM: begin
                ma_w = AW'(vp_reg);
                mb_w = clip_reg ? BW'(clip_reg_b) : ae_reg;
            end
            rskp_pkg::MUL_VP_R: begin
                ma_w = AW'(vp_reg);
                mb_w = BW'(r_reg);
            end
            default: begin
                ma_w = '0;
                mb_w = '0;
            end
        endcase
    end

    // clip test: rq*|e|*2^16 > b*S*2^F
    logic [CMP_W-1:0] lhs_w, rhs_w;
    assign lhs_w = CMP_W'({lhs_reg, 16'b0});
    assign rhs_w = CMP_W'(p_reg) << POS_FRAC_BITS;

    // divider step
    logic [VW:0] dt_w;
    logic        dbit;
    assign dt_w = {dr_reg[VW-1:0], dq_reg[DW-1]};
    assign dbit = (dt_w >= {1'b0, dd_reg});

    // position update
    logic [16:0]        mag_w;
    logic signed [18:0] sum_w;
    logic signed [15:0] est_new_w;
    always_comb begin
        if (zero_reg)              mag_w = '0;
        else if (|dq_reg[DW-1:17]) mag_w = '1;
        else                       mag_w = dq_reg[16:0];
        sum_w = neg_reg ? (19'(est_reg) - 19'($signed({2'b00, mag_w})))
                        : (19'(est_reg) + 19'($signed({2'b00, mag_w})));
        if (sum_w > 19'sd32767)       est_new_w = 16'sh7FFF;
        else if (sum_w < -19'sd32768) est_new_w = -16'sh8000;
        else                          est_new_w = sum_w[15:0];
    end

    // variance update
    logic [32:0] vq_w;
    logic [31:0] var_new_w;
    assign vq_w      = {1'b0, q_reg, 16'b0} + (sqz_reg ? 33'd0 : {1'b0, dq_reg[31:0]});
    assign var_new_w = vq_w[32] ? 32'hFFFF_FFFF : vq_w[31:0];

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            ax_reg <= s_tuser;
            s_reg  <= s_tdata;
        end
        if (cmd.prep1) begin
            q_reg   <= interior ? qc_reg : qb_reg;
            r_reg   <= interior ? rc_reg : rb_reg;
            est_reg <= est_st_reg[ax_reg];
            v_reg   <= var_st_reg[ax_reg];
        end
        if (cmd.prep2) begin
            vp_reg  <= {1'b0, v_reg} + {1'b0, q_reg, 16'b0};
            neg_reg <= e_w[16];
            ae_reg  <= e_w[16] ? 17'(-e_w) : 17'(e_w);
        end
        if (cmd.prep3) begin
            sq_reg   <= {1'b0, vp_reg} + {2'b00, r_reg, 16'b0};
            sx_reg   <= {r_reg, 16'b0};
            srem_reg <= '0;
            root_reg <= '0;
        end
        if (cmd.sqrt_step) begin
            sx_reg <= sx_reg << 2;
            if (rem2_w >= trial_w) begin
                srem_reg <= 18'(rem2_w - trial_w);
                root_reg <= {root_reg[14:0], 1'b1};
            end else begin
                srem_reg <= rem2_w[17:0];
                root_reg <= {root_reg[14:0], 1'b0};
            end
        end
        if (cmd.mul_op != rskp_pkg::MUL_NONE) begin
            p_reg <= PW'(ma_w) * PW'(mb_w);
        end
        if (cmd.lhs_cap) begin
            lhs_reg <= p_reg[32:0];
        end
        if (cmd.clip_cap) begin
            sqz_reg  <= (sq_reg == '0);
            zero_reg <= (sq_reg == '0) || (ae_reg == '0);
            clip_reg <= (root_reg != '0) && (lhs_w > rhs_w);
        end
        if (cmd.div_load_pos) begin
            dr_reg <= '0;
            if (clip_reg) begin
                dq_reg <= (DW'(p_reg) << (POS_FRAC_BITS + 1)) + DW'({root_reg, 16'b0});
                dd_reg <= VW'({root_reg, 17'b0});
            end else begin
                dq_reg <= DW'({p_reg, 1'b0}) + DW'(sq_reg);
                dd_reg <= VW'({sq_reg, 1'b0});
            end
        end
        if (cmd.div_load_var) begin
            dr_reg <= '0;
            dq_reg <= {p_reg[DW-17:0], 16'b0};
            dd_reg <= VW'(sq_reg);
        end
        if (cmd.div_step) begin
            dr_reg <= dbit ? (dt_w - {1'b0, dd_reg}) : dt_w;
            dq_reg <= {dq_reg[DW-2:0], dbit};
        end
        if (cmd.pos_upd) begin
            res_reg <= est_new_w;
        end
        if (cmd.out_load) begin
            m_tuser <= ax_reg;
            m_tdata <= res_reg;
        end
    end

    // filter state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            est_st_reg[0] <= rskp_pkg::center_of(rskp_pkg::SCREEN_WIDTH_RST, POS_FRAC_BITS);
            est_st_reg[1] <= rskp_pkg::center_of(rskp_pkg::SCREEN_HEIGHT_RST, POS_FRAC_BITS);
            var_st_reg[0] <= rskp_pkg::VAR_RST;
            var_st_reg[1] <= rskp_pkg::VAR_RST;
        end else begin
            if (cmd.pos_upd) est_st_reg[ax_reg] <= est_new_w;
            if (cmd.var_upd) var_st_reg[ax_reg] <= var_new_w;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    assign m_tvalid     = m_tvalid_reg;
    assign sts.out_free = !m_tvalid_reg || m_tready;

endmodule

// ===== hw/rtl/robust_scalar_kalman_position.sv =====
// top level of the robust scalar kalman position filter
//
//  channel  dir  handshake            payload
//  s_       in   s_tvalid/s_tready    s_tuser = axis, s_tdata = sample
//  m_       out  m_tvalid/m_tready    m_tuser = axis_out, m_tdata = estimate
//  cfg_     in   cfg_wr_en            cfg_addr = register index, cfg_wdata = value
//
// one request at a time; the work from accept to result valid includes the two
// 65-step restoring divisions (gain and variance) plus a 16-step square root
// s_tready is high only while idle; a result waiting in the output register does
// not block the next accept, only the final load of the following result
// reset is synchronous, active low, and restores config registers, output valid and both axis states
module robust_scalar_kalman_position #(
    parameter int POS_FRAC_BITS = rskp_pkg::POS_FRAC_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [2:0]         cfg_addr,
    input  logic [15:0]        cfg_wdata,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic               s_tuser,   // axis
    input  logic signed [15:0] s_tdata,   // sample
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic               m_tuser,   // axis_out
    output logic signed [15:0] m_tdata    // estimate
);

    rskp_pkg::cmd_t cmd;
    rskp_pkg::sts_t sts;

    rskp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    rskp_dp #(
        .POS_FRAC_BITS (POS_FRAC_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tuser   (m_tuser),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

// ===== hw/rtl/rskp_checker.sv =====
// port-level checks for the robust scalar kalman position filter, bound to the top
module rskp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic        m_tuser,
    input logic [15:0] m_tdata
);

    // no result survives a reset
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // one request in flight: busy right after an accept
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("accepted a second request while busy");

    // a new result only appears at the end of the work, never while idle
    a_result_from_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result appeared without work in progress");

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

endmodule

bind robust_scalar_kalman_position rskp_checker u_rskp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tuser  (m_tuser),
    .m_tdata  (m_tdata)
);
